>>> hw/rtl/elr_pkg.sv
// ----------------------------------------------------------------------------
// elr_pkg
// Shared types and constants of the edge length relaxation block.
// ----------------------------------------------------------------------------
package elr_pkg;

  localparam int unsigned NUM_VERTICES = 1024;
  localparam int unsigned IDX_W        = 10;
  localparam int unsigned ADDR_W       = $clog2(NUM_VERTICES);
  localparam int unsigned COORD_W      = 32;
  localparam int unsigned VERT_W       = 3 * COORD_W;
  localparam int unsigned HALF_Q16     = 32768;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_RELAX = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [IDX_W-1:0]   index_a;
    logic [IDX_W-1:0]   index_b;
    logic [31:0]        rest_len_sq;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               last_edge;
  } in_word_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } out_word_t;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -35'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
    return {1'b0, idx} < (IDX_W+1)'(NUM_VERTICES);
  endfunction

endpackage

>>> hw/rtl/elr_ram.sv
// ----------------------------------------------------------------------------
// elr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module elr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/edge_length_relaxation_top.sv
// ----------------------------------------------------------------------------
// edge_length_relaxation_top
// Vertex position store with sqrt-free edge length relaxation.
// ----------------------------------------------------------------------------
// One item is processed at a time. A write is done in its accept cycle, a read
// passes through the accept cycle, a read of the position RAM and the emit state
// plus output wait. A relax item passes through the accept cycle, two reads of
// the position RAM, the shared squaring multiplier, forming the denominator, the
// bit-serial divider, the correction multiplier and two write-backs (plus an
// emit state for a sweep-done word). With a zero denominator the divider is
// skipped.
module edge_length_relaxation_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  elr_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output elr_pkg::out_word_t  out_word_o
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_RDA  = 10'b0000000010,
    S_RDB  = 10'b0000000100,
    S_SQ   = 10'b0000001000,
    S_DEN  = 10'b0000010000,
    S_DIV  = 10'b0000100000,
    S_MUL  = 10'b0001000000,
    S_WRA  = 10'b0010000000,
    S_WRB  = 10'b0100000000,
    S_EMIT = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [elr_pkg::IDX_W-1:0] ia_q, ib_q;
  logic [31:0]               r_q;
  logic                      last_q, relax_q, oor_q;
  logic [elr_pkg::VERT_W-1:0] pa_q, pb_q;
  logic signed [32:0]        d_q    [3];
  logic signed [34:0]        corr_q [3];
  logic [49:0]               dd_q;
  logic [50:0]               den_q;
  logic [51:0]               rem_q;
  logic [16:0]               q_q;
  logic [1:0]                k_q;
  logic [4:0]                cnt_q;

  logic                       out_valid_q;
  elr_pkg::out_word_t         out_q;

  logic                        we;
  logic [elr_pkg::ADDR_W-1:0]  waddr, raddr;
  logic [elr_pkg::VERT_W-1:0]  wdata, rdata;

  logic                       accept, out_free;
  logic signed [32:0]         d_k;
  logic [32:0]                mag;
  logic [65:0]                sq;
  logic [51:0]                trial;
  logic signed [17:0]         f;
  logic signed [50:0]         fprod;
  logic [elr_pkg::VERT_W-1:0] wa_val, wb_val;

  elr_ram #(
    .WIDTH (elr_pkg::VERT_W),
    .DEPTH (elr_pkg::NUM_VERTICES)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  assign d_k   = d_q[k_q];
  assign mag   = d_k[32] ? 33'(-d_k) : 33'(d_k);
  assign sq    = 66'(mag) * 66'(mag);
  assign trial = {rem_q[50:0], (cnt_q == 5'd16) ? r_q[0] : 1'b0};
  assign f     = $signed({1'b0, q_q}) - 18'sd32768;
  assign fprod = 51'(f) * 51'(d_k);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      wa_val[k*32 +: 32] = elr_pkg::sat32(35'($signed(pa_q[k*32 +: 32])) - corr_q[k]);
      wb_val[k*32 +: 32] = elr_pkg::sat32(35'($signed(pb_q[k*32 +: 32])) + corr_q[k]);
    end
  end

  always_comb begin
    raddr = in_word_i.index_a[elr_pkg::ADDR_W-1:0];
    if (state_q == S_RDA) begin
      raddr = ib_q[elr_pkg::ADDR_W-1:0];
    end
    we    = 1'b0;
    waddr = ia_q[elr_pkg::ADDR_W-1:0];
    wdata = wa_val;
    unique case (state_q)
      S_IDLE: begin
        we    = accept && (in_word_i.opcode == elr_pkg::OP_WRITE) &&
                elr_pkg::idx_ok(in_word_i.index_a);
        waddr = in_word_i.index_a[elr_pkg::ADDR_W-1:0];
        wdata = {in_word_i.pos_z, in_word_i.pos_y, in_word_i.pos_x};
      end
      S_WRA: we = 1'b1;
      S_WRB: begin
        we    = 1'b1;
        waddr = ib_q[elr_pkg::ADDR_W-1:0];
        wdata = wb_val;
      end
      default: we = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_word_i.opcode)
            elr_pkg::OP_READ:  state_d = S_RDA;
            elr_pkg::OP_RELAX: begin
              if (elr_pkg::idx_ok(in_word_i.index_a) && elr_pkg::idx_ok(in_word_i.index_b)) begin
                state_d = S_RDA;
              end else if (in_word_i.last_edge) begin
                state_d = S_EMIT;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_RDA:  state_d = relax_q ? S_RDB : S_EMIT;
      S_RDB:  state_d = S_SQ;
      S_SQ:   state_d = (k_q == 2'd2) ? S_DEN : S_SQ;
      S_DEN:  state_d = (dd_q == '0 && r_q == '0) ? S_MUL : S_DIV;
      S_DIV:  state_d = (cnt_q == '0) ? S_MUL : S_DIV;
      S_MUL:  state_d = (k_q == 2'd2) ? S_WRA : S_MUL;
      S_WRA:  state_d = S_WRB;
      S_WRB:  state_d = last_q ? S_EMIT : S_IDLE;
      S_EMIT: state_d = out_free ? S_IDLE : S_EMIT;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        ia_q    <= in_word_i.index_a;
        ib_q    <= in_word_i.index_b;
        r_q     <= in_word_i.rest_len_sq;
        last_q  <= in_word_i.last_edge;
        relax_q <= (in_word_i.opcode == elr_pkg::OP_RELAX);
        oor_q   <= !elr_pkg::idx_ok(in_word_i.index_a);
        dd_q    <= '0;
        k_q     <= '0;
      end
      S_RDA: pa_q <= oor_q ? '0 : rdata;
      S_RDB: begin
        pb_q <= rdata;
        for (int k = 0; k < 3; k++) begin
          d_q[k] <= 33'($signed(rdata[k*32 +: 32])) - 33'($signed(pa_q[k*32 +: 32]));
        end
      end
      S_SQ: begin
        dd_q <= dd_q + 50'(sq[65:16]);
        k_q  <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
      end
      S_DEN: begin
        den_q <= 51'(dd_q) + 51'(r_q);
        rem_q <= 52'(r_q[31:1]);
        q_q   <= (dd_q == '0 && r_q == '0) ? 17'(elr_pkg::HALF_Q16) : '0;
        cnt_q <= 5'd16;
      end
      S_DIV: begin
        if (trial >= 52'(den_q)) begin
          rem_q        <= trial - 52'(den_q);
          q_q[cnt_q]   <= 1'b1;
        end else begin
          rem_q <= trial;
        end
        cnt_q <= cnt_q - 5'd1;
      end
      S_MUL: begin
        corr_q[k_q] <= fprod[50:16];
        k_q         <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
      end
      S_EMIT: begin
        if (out_free) begin
          out_q.result_kind <= relax_q ? elr_pkg::KIND_DONE : elr_pkg::KIND_READ;
          out_q.out_x       <= relax_q ? '0 : pa_q[31:0];
          out_q.out_y       <= relax_q ? '0 : pa_q[63:32];
          out_q.out_z       <= relax_q ? '0 : pa_q[95:64];
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives vertex writes, edge relaxations and reads into the relaxation block
// and checks every returned word against a cycle-free prediction of the
// vertex store, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NV      = 64;
  localparam int LIMIT   = 20000;
  localparam int LATENCY = 64;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  elr_pkg::in_word_t  in_word_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  elr_pkg::out_word_t out_word_o;

  edge_length_relaxation_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic signed [31:0] vert_mem [elr_pkg::NUM_VERTICES][3];
  elr_pkg::out_word_t pending_words [$];
  int                 mismatches = 0;
  int                 words_seen = 0;
  int                 idle_cycles = 0;
  bit                 quiet = 1'b0;
  int                 n_relax = 0;
  int                 n_read = 0;

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint floor16(longint p);
    return p >>> 16;
  endfunction

  task automatic predict_relax(int ia, int ib, longint unsigned r);
    longint           d [3];
    longint unsigned  dd;
    longint unsigned  den;
    longint unsigned  q;
    longint unsigned  m;
    longint           f;
    longint           corr [3];
    dd = 0;
    f = 0;
    for (int k = 0; k < 3; k++) begin
      d[k] = longint'(vert_mem[ib][k]) - longint'(vert_mem[ia][k]);
      m = (d[k] < 0) ? -d[k] : d[k];
      dd += (m * m) >> 16;
    end
    den = dd + r;
    if (den != 0) begin
      q = (r << 16) / den;
      f = longint'(q) - elr_pkg::HALF_Q16;
    end
    for (int k = 0; k < 3; k++) corr[k] = floor16(f * d[k]);
    for (int k = 0; k < 3; k++) vert_mem[ia][k] = clamp32(longint'(vert_mem[ia][k]) - corr[k]);
    for (int k = 0; k < 3; k++) vert_mem[ib][k] = clamp32(longint'(vert_mem[ib][k]) + corr[k]);
  endtask

  task automatic predict_word(elr_pkg::in_word_t w);
    elr_pkg::out_word_t o;
    o = '0;
    case (elr_pkg::opcode_e'(w.opcode))
      elr_pkg::OP_WRITE: begin
        vert_mem[w.index_a] = '{w.pos_x, w.pos_y, w.pos_z};
      end
      elr_pkg::OP_RELAX: begin
        n_relax++;
        predict_relax(w.index_a, w.index_b, w.rest_len_sq);
        if (w.last_edge) begin
          o.result_kind = elr_pkg::KIND_DONE;
          pending_words.push_back(o);
        end
      end
      elr_pkg::OP_READ: begin
        n_read++;
        o.result_kind = elr_pkg::KIND_READ;
        o.out_x = vert_mem[w.index_a][0];
        o.out_y = vert_mem[w.index_a][1];
        o.out_z = vert_mem[w.index_a][2];
        pending_words.push_back(o);
      end
      default: ;
    endcase
  endtask

  task automatic send_word(elr_pkg::in_word_t w);
    while (!quiet && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_word(w);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) out_stall_i <= !quiet && ($urandom_range(99) < 8);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      elr_pkg::out_word_t e;
      words_seen++;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", out_word_o);
      end else begin
        e = pending_words.pop_front();
        if (out_word_o !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %h actual %h", e, out_word_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic elr_pkg::in_word_t mk(logic [1:0] op, int a, int b);
    elr_pkg::in_word_t w;
    w.opcode = op;
    w.index_a = a[elr_pkg::IDX_W-1:0];
    w.index_b = b[elr_pkg::IDX_W-1:0];
    w.rest_len_sq = $urandom;
    w.pos_x = $urandom;
    w.pos_y = $urandom;
    w.pos_z = $urandom;
    w.last_edge = 1'($urandom_range(1));
    return w;
  endfunction

  function automatic logic signed [31:0] rnd_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(20 << 16)) - (10 << 16);
      2: return ($urandom_range(1)) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(1 << 17)) - (1 << 16);
    endcase
  endfunction

  task automatic write_vertex(int a, logic signed [31:0] x, y, z);
    elr_pkg::in_word_t w;
    w = mk(elr_pkg::OP_WRITE, a, $urandom_range(1023));
    w.pos_x = x;
    w.pos_y = y;
    w.pos_z = z;
    send_word(w);
  endtask

  task automatic relax(int a, int b, logic [31:0] r, logic last);
    elr_pkg::in_word_t w;
    w = mk(elr_pkg::OP_RELAX, a, b);
    w.rest_len_sq = r;
    w.last_edge = last;
    send_word(w);
  endtask

  task automatic read_vertex(int a);
    send_word(mk(elr_pkg::OP_READ, a, $urandom_range(1023)));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic test_directed();
    write_vertex(0, 32'sh7fffffff, 32'sh80000000, 0);
    write_vertex(1023, 32'sh80000000, 32'sh7fffffff, -1);
    write_vertex(1, 1 << 16, 0, 0);
    write_vertex(2, 0, 0, 0);
    read_vertex(0);
    read_vertex(1023);
    relax(1, 2, 32'd0, 1'b0);
    relax(1, 1, 32'd4 << 16, 1'b1);
    write_vertex(3, 0, 0, 0);
    relax(2, 3, 32'd0, 1'b1);
    relax(0, 1023, 32'hffffffff, 1'b0);
    relax(1, 2, 32'hffffffff, 1'b1);
    relax(0, 1023, 32'd0, 1'b1);
    send_word(mk(elr_pkg::OP_NONE, 5, 6));
    read_vertex(0);
    read_vertex(1);
    read_vertex(2);
    read_vertex(1023);
  endtask

  task automatic test_pause();
    drain();
    read_vertex(1);
  endtask

  task automatic test_sweeps();
    int n;
    int a;
    for (int i = 0; i < NV; i++)
      write_vertex(i, rnd_coord(), rnd_coord(), rnd_coord());
    n = 0;
    while (n < 900) begin
      int e = $urandom_range(4, 12);
      int s = $urandom_range(NV - 14);
      for (int j = 0; j < e; j++)
        relax(s + j, s + j + 1, $urandom_range(3) == 0 ? $urandom : $urandom_range(8 << 16),
              j == e - 1);
      for (int j = e - 1; j >= 0; j--)
        relax(s + j + 1, s + j, $urandom_range(8 << 16), j == 0);
      n += 2 * e;
      repeat ($urandom_range(1, 4)) begin
        a = $urandom_range(NV - 1);
        case ($urandom_range(3))
          0: write_vertex(a, rnd_coord(), rnd_coord(), rnd_coord());
          1: relax(a, $urandom_range(NV - 1), $urandom, 1'($urandom_range(1)));
          2: send_word(mk(elr_pkg::OP_NONE, $urandom, $urandom));
          default: read_vertex(a);
        endcase
        n++;
      end
      if (n > 300 && n < 340) quiet = 1'b1;
      if (n > 500) quiet = 1'b0;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_pause();
    test_sweeps();
    drain();
    $display("Covered %0d relax and %0d read words, %0d result words checked, %0d mismatches.",
             n_relax, n_read, words_seen, mismatches);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
